@@ rtl/core/mmcd_pkg.sv @@
`timescale 1ns / 1ps

package mmcd_pkg;

    localparam int VALUE_WIDTH     = 24;
    localparam int POS_WIDTH       = 32;
    localparam int COUNT_WIDTH     = 24;
    localparam int PIXEL_WIDTH     = 13;
    localparam int COLUMN_WIDTH    = 12;
    localparam int REM_WIDTH       = COUNT_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [COUNT_WIDTH-1:0] POINT_COUNT_RESET = 24'd4096;
    localparam logic [PIXEL_WIDTH-1:0] PIXEL_COUNT_RESET = 13'd1024;
    localparam logic [PIXEL_WIDTH-1:0] MAX_COLUMNS       = 13'd4096;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENVELOPE_MODE = 2'd2;

    typedef struct packed {
        logic [POS_WIDTH-1:0]          sample_pos;
        logic signed [VALUE_WIDTH-1:0] sample_val;
    } in_item_t;

    typedef struct packed {
        logic [POS_WIDTH-1:0]          first_pos;
        logic signed [VALUE_WIDTH-1:0] first_val;
        logic [POS_WIDTH-1:0]          second_pos;
        logic signed [VALUE_WIDTH-1:0] second_val;
        logic [COLUMN_WIDTH-1:0]       column_index;
        logic                          frame_last;
    } out_item_t;

    typedef struct packed {
        logic                    close;
        logic                    last;
        logic [COLUMN_WIDTH-1:0] column_index;
    } bound_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] min_val;
        logic [POS_WIDTH-1:0]          min_pos;
        logic signed [VALUE_WIDTH-1:0] max_val;
        logic [POS_WIDTH-1:0]          max_pos;
    } extrema_t;

    // A point count of zero behaves as one.
    function automatic logic [COUNT_WIDTH-1:0] eff_points(input logic [COUNT_WIDTH-1:0] pc);
        return (pc == '0) ? COUNT_WIDTH'(1) : pc;
    endfunction

    // Column count clamped to 1..min(points, MAX_COLUMNS).
    function automatic logic [PIXEL_WIDTH-1:0] eff_columns(
        input logic [COUNT_WIDTH-1:0] n,
        input logic [PIXEL_WIDTH-1:0] pix
    );
        logic [PIXEL_WIDTH-1:0] p;
        p = (pix == '0) ? PIXEL_WIDTH'(1) : pix;
        if ({{(COUNT_WIDTH-PIXEL_WIDTH){1'b0}}, p} > n)
        begin
            p = n[PIXEL_WIDTH-1:0];
        end
        if (p > MAX_COLUMNS)
        begin
            p = MAX_COLUMNS;
        end
        return p;
    endfunction

endpackage

@@ rtl/core/min_max_column_decimator_unit.sv @@
`timescale 1ns / 1ps

// Min/max column decimator. Samples of a frame arrive as requests on the
// in_valid/in_ready channel; each closed column leaves as one request on the
// out_valid/out_ready channel carrying the column's minimum and maximum points
// (ordered by position) or, in envelope mode, the mid position with both values.
// A request is taken into an input register, then processed by the
// compare-and-update logic and the column boundary counter; the result of
// a closing sample lands in an output register. One sample can be accepted
// every cycle while no closing sample is held back by a stalled receiver;
// the update of the running extremes and boundary remainder in each step sets that rate.
// When the receiver stalls, the output register holds its result and samples
// that do not close a column keep flowing; a closing sample waits in the input
// register, and in_ready drops once both registers are full.
// Reset sets 4096 points, 1024 columns and order mode, and starts a new frame.
// Writes to point_count or pixel_count restart the frame; write them only while
// the block is idle.
module min_max_column_decimator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  mmcd_pkg::in_item_t                     in_item,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output mmcd_pkg::out_item_t                    out_item,
    input  logic                                   cfg_we,
    input  logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mmcd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    logic [mmcd_pkg::COUNT_WIDTH-1:0] point_count_reg, point_count_next;
    logic [mmcd_pkg::PIXEL_WIDTH-1:0] pixel_count_reg, pixel_count_next;
    logic                             envelope_mode_reg, envelope_mode_next;

    logic                             in_valid_reg;
    mmcd_pkg::in_item_t               in_item_reg;
    logic                             out_valid_reg;
    mmcd_pkg::out_item_t              out_item_reg, out_item_next;

    logic [mmcd_pkg::COUNT_WIDTH-1:0] n, n_next;
    logic [mmcd_pkg::PIXEL_WIDTH-1:0] p;
    logic                             restart;
    logic                             step;
    mmcd_pkg::bound_t                 bound;
    mmcd_pkg::extrema_t               cur;
    logic [mmcd_pkg::POS_WIDTH:0]     mid_sum;
    logic [mmcd_pkg::POS_WIDTH-1:0]   mid_pos;

    always_comb
    begin
        point_count_next   = point_count_reg;
        pixel_count_next   = pixel_count_reg;
        envelope_mode_next = envelope_mode_reg;
        if (cfg_we)
        begin
            if (cfg_index == mmcd_pkg::CFG_POINT_COUNT)
            begin
                point_count_next = cfg_data[mmcd_pkg::COUNT_WIDTH-1:0];
            end
            else if (cfg_index == mmcd_pkg::CFG_PIXEL_COUNT)
            begin
                pixel_count_next = cfg_data[mmcd_pkg::PIXEL_WIDTH-1:0];
            end
            else if (cfg_index == mmcd_pkg::CFG_ENVELOPE_MODE)
            begin
                envelope_mode_next = cfg_data[0];
            end
        end
    end

    assign restart = cfg_we && ((cfg_index == mmcd_pkg::CFG_POINT_COUNT) ||
                                (cfg_index == mmcd_pkg::CFG_PIXEL_COUNT));
    assign n       = mmcd_pkg::eff_points(point_count_reg);
    assign n_next  = mmcd_pkg::eff_points(point_count_next);
    assign p       = mmcd_pkg::eff_columns(n, pixel_count_reg);

    assign step     = in_valid_reg && (!bound.close || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    mmcd_boundary u_boundary (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .restart (restart),
        .n       (n),
        .n_next  (n_next),
        .p       (p),
        .bound   (bound)
    );

    mmcd_extrema u_extrema (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .close   (bound.close),
        .restart (restart),
        .sample  (in_item_reg),
        .cur     (cur)
    );

    assign mid_sum = {1'b0, cur.min_pos} + {1'b0, cur.max_pos};
    assign mid_pos = mid_sum[mmcd_pkg::POS_WIDTH:1];

    always_comb
    begin
        out_item_next.column_index = bound.column_index;
        out_item_next.frame_last   = bound.last;
        if (envelope_mode_reg)
        begin
            out_item_next.first_pos  = mid_pos;
            out_item_next.first_val  = cur.min_val;
            out_item_next.second_pos = mid_pos;
            out_item_next.second_val = cur.max_val;
        end
        else if (cur.min_pos < cur.max_pos)
        begin
            out_item_next.first_pos  = cur.min_pos;
            out_item_next.first_val  = cur.min_val;
            out_item_next.second_pos = cur.max_pos;
            out_item_next.second_val = cur.max_val;
        end
        else
        begin
            out_item_next.first_pos  = cur.max_pos;
            out_item_next.first_val  = cur.max_val;
            out_item_next.second_pos = cur.min_pos;
            out_item_next.second_val = cur.min_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= mmcd_pkg::POINT_COUNT_RESET;
            pixel_count_reg   <= mmcd_pkg::PIXEL_COUNT_RESET;
            envelope_mode_reg <= 1'b0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            point_count_reg   <= point_count_next;
            pixel_count_reg   <= pixel_count_next;
            envelope_mode_reg <= envelope_mode_next;
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step && bound.close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
        if (step && bound.close)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while the output register is empty");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bound.column_index} < p)
        else $error("column counter beyond the effective column count");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && bound.last |=> bound.column_index == '0)
        else $error("column counter not cleared after the frame end");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled result changed or dropped");

endmodule

@@ rtl/core/mmcd_boundary.sv @@
`timescale 1ns / 1ps

module mmcd_boundary (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic                                 restart,
    input  logic [mmcd_pkg::COUNT_WIDTH-1:0]     n,
    input  logic [mmcd_pkg::COUNT_WIDTH-1:0]     n_next,
    input  logic [mmcd_pkg::PIXEL_WIDTH-1:0]     p,
    output mmcd_pkg::bound_t                     bound
);

    logic [mmcd_pkg::COUNT_WIDTH-1:0]  sample_cnt_reg, sample_cnt_next;
    logic [mmcd_pkg::COLUMN_WIDTH-1:0] column_cnt_reg, column_cnt_next;
    logic [mmcd_pkg::REM_WIDTH-1:0]    rem_reg, rem_next;
    logic [mmcd_pkg::REM_WIDTH-1:0]    rem_sub;
    logic [mmcd_pkg::REM_WIDTH-1:0]    p_wide;
    logic [mmcd_pkg::REM_WIDTH-1:0]    sample_inc;
    logic [mmcd_pkg::PIXEL_WIDTH-1:0]  column_inc;
    logic                              last;
    logic                              close;

    assign p_wide     = mmcd_pkg::REM_WIDTH'(p);
    assign rem_sub    = (rem_reg >= p_wide) ? (rem_reg - p_wide) : '0;
    assign sample_inc = {1'b0, sample_cnt_reg} + mmcd_pkg::REM_WIDTH'(1);
    assign column_inc = {1'b0, column_cnt_reg} + mmcd_pkg::PIXEL_WIDTH'(1);
    assign last       = sample_inc >= {1'b0, n};
    assign close      = last || ((rem_sub < p_wide) && (column_inc < p));

    assign bound.close        = close;
    assign bound.last         = last;
    assign bound.column_index = column_cnt_reg;

    always_comb
    begin
        sample_cnt_next = sample_cnt_reg;
        column_cnt_next = column_cnt_reg;
        rem_next        = rem_reg;
        if (restart || (step && last))
        begin
            sample_cnt_next = '0;
            column_cnt_next = '0;
            rem_next        = {1'b0, n_next};
        end
        else if (step)
        begin
            sample_cnt_next = sample_inc[mmcd_pkg::COUNT_WIDTH-1:0];
            if (close)
            begin
                column_cnt_next = column_inc[mmcd_pkg::COLUMN_WIDTH-1:0];
                rem_next        = rem_sub + {1'b0, n};
            end
            else
            begin
                rem_next = rem_sub;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            column_cnt_reg <= '0;
            rem_reg        <= {1'b0, mmcd_pkg::POINT_COUNT_RESET};
        end
        else
        begin
            sample_cnt_reg <= sample_cnt_next;
            column_cnt_reg <= column_cnt_next;
            rem_reg        <= rem_next;
        end
    end

endmodule

@@ rtl/core/mmcd_extrema.sv @@
`timescale 1ns / 1ps

module mmcd_extrema (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  close,
    input  logic                  restart,
    input  mmcd_pkg::in_item_t    sample,
    output mmcd_pkg::extrema_t    cur
);

    mmcd_pkg::extrema_t ext_reg;
    logic               open_reg, open_next;

    // A sample equal to the current extreme leaves the earlier one in place.
    always_comb
    begin
        cur = ext_reg;
        if (!open_reg)
        begin
            cur.min_val = sample.sample_val;
            cur.min_pos = sample.sample_pos;
            cur.max_val = sample.sample_val;
            cur.max_pos = sample.sample_pos;
        end
        else
        begin
            if (sample.sample_val < ext_reg.min_val)
            begin
                cur.min_val = sample.sample_val;
                cur.min_pos = sample.sample_pos;
            end
            if (sample.sample_val > ext_reg.max_val)
            begin
                cur.max_val = sample.sample_val;
                cur.max_pos = sample.sample_pos;
            end
        end
    end

    always_comb
    begin
        open_next = open_reg;
        if (restart)
        begin
            open_next = 1'b0;
        end
        else if (step)
        begin
            open_next = !close;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            ext_reg <= cur;
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 50;
    localparam int HOLD_SAMPLES = 80;
    localparam int STEADY_SAMPLES = 100;

    typedef struct {
        bit                                        write;
        logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0]      index;
        logic [mmcd_pkg::CFG_DATA_WIDTH-1:0]       data;
        mmcd_pkg::in_item_t                        sample;
        bit                                        typed;
        mmcd_pkg::out_item_t                       want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mmcd_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mmcd_pkg::out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [mmcd_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

    logic [mmcd_pkg::COUNT_WIDTH-1:0] points_reg;
    logic [mmcd_pkg::PIXEL_WIDTH-1:0] columns_reg;
    bit envelope_reg;
    logic [mmcd_pkg::COUNT_WIDTH-1:0] frame_sample;
    logic [mmcd_pkg::COLUMN_WIDTH-1:0] frame_column;
    logic [39:0] boundary_rem;
    bit column_active;
    logic signed [mmcd_pkg::VALUE_WIDTH-1:0] low_val;
    logic [mmcd_pkg::POS_WIDTH-1:0] low_pos;
    logic signed [mmcd_pkg::VALUE_WIDTH-1:0] high_val;
    logic [mmcd_pkg::POS_WIDTH-1:0] high_pos;

    mmcd_pkg::out_item_t pending_columns[$];
    step_t directed_steps[$];
    logic [mmcd_pkg::POS_WIDTH-1:0] pos_ramp = '0;
    int failures = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    bit steady_flow = 1'b0;

    min_max_column_decimator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void open_frame();
        frame_sample = '0;
        frame_column = '0;
        boundary_rem = (points_reg == '0) ? 40'd1 : 40'(points_reg);
        column_active = 1'b0;
        low_val = '0;
        low_pos = '0;
        high_val = '0;
        high_pos = '0;
    endfunction

    // Folds one sample into the open column and returns 1 when the column closes.
    function automatic bit fold_sample(input mmcd_pkg::in_item_t s,
                                       output mmcd_pkg::out_item_t r);
        logic [24:0] n;
        logic [12:0] p;
        logic [39:0] rem;
        logic [32:0] mid;
        bit last;
        bit close;
        n = (points_reg == '0) ? 25'd1 : {1'b0, points_reg};
        p = (columns_reg == '0) ? 13'd1 : columns_reg;
        if ({12'd0, p} > n)
        begin
            p = n[12:0];
        end
        if (p > mmcd_pkg::MAX_COLUMNS)
        begin
            p = mmcd_pkg::MAX_COLUMNS;
        end
        r = '0;
        if (!column_active)
        begin
            low_val = s.sample_val;
            high_val = s.sample_val;
            low_pos = s.sample_pos;
            high_pos = s.sample_pos;
            column_active = 1'b1;
        end
        else
        begin
            if ($signed(s.sample_val) < $signed(low_val))
            begin
                low_val = s.sample_val;
                low_pos = s.sample_pos;
            end
            if ($signed(s.sample_val) > $signed(high_val))
            begin
                high_val = s.sample_val;
                high_pos = s.sample_pos;
            end
        end
        last = ({1'b0, frame_sample} + 25'd1) >= n;
        rem = (boundary_rem >= 40'(p)) ? boundary_rem - 40'(p) : 40'd0;
        close = last || (rem < 40'(p) && ({1'b0, frame_column} + 13'd1) < p);
        if (!close)
        begin
            frame_sample = frame_sample + 1'b1;
            boundary_rem = rem;
            return 1'b0;
        end
        if (envelope_reg)
        begin
            mid = ({1'b0, low_pos} + {1'b0, high_pos}) >> 1;
            r.first_pos = mid[31:0];
            r.first_val = low_val;
            r.second_pos = mid[31:0];
            r.second_val = high_val;
        end
        else if (low_pos < high_pos)
        begin
            r.first_pos = low_pos;
            r.first_val = low_val;
            r.second_pos = high_pos;
            r.second_val = high_val;
        end
        else
        begin
            r.first_pos = high_pos;
            r.first_val = high_val;
            r.second_pos = low_pos;
            r.second_val = low_val;
        end
        r.column_index = frame_column;
        r.frame_last = last;
        column_active = 1'b0;
        if (last)
        begin
            open_frame();
        end
        else
        begin
            frame_column = frame_column + 1'b1;
            frame_sample = frame_sample + 1'b1;
            boundary_rem = rem + 40'(n);
        end
        return 1'b1;
    endfunction

    function automatic mmcd_pkg::in_item_t random_sample();
        mmcd_pkg::in_item_t s;
        case ($urandom_range(0, 3))
            0: s.sample_pos = $urandom;
            1: s.sample_pos = 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: s.sample_pos = $urandom_range(0, 3);
            default:
            begin
                pos_ramp = pos_ramp + $urandom_range(0, 64);
                s.sample_pos = pos_ramp;
            end
        endcase
        case ($urandom_range(0, 5))
            0: s.sample_val = 24'h800000;
            1: s.sample_val = 24'h7FFFFF;
            2: s.sample_val = 24'($urandom_range(0, 6) - 3);
            default: s.sample_val = 24'($urandom);
        endcase
        return s;
    endfunction

    function automatic void add_write(input logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                      input logic [mmcd_pkg::CFG_DATA_WIDTH-1:0] data);
        step_t st;
        st = '{default: '0};
        st.write = 1'b1;
        st.index = idx;
        st.data = data;
        directed_steps.push_back(st);
    endfunction

    function automatic void add_sample(input logic [mmcd_pkg::POS_WIDTH-1:0] pos,
                                       input logic [mmcd_pkg::VALUE_WIDTH-1:0] val);
        step_t st;
        st = '{default: '0};
        st.sample.sample_pos = pos;
        st.sample.sample_val = val;
        directed_steps.push_back(st);
    endfunction

    function automatic void add_typed(input logic [mmcd_pkg::POS_WIDTH-1:0] pos,
                                      input logic [mmcd_pkg::VALUE_WIDTH-1:0] val,
                                      input logic [mmcd_pkg::POS_WIDTH-1:0] pos_a,
                                      input logic [mmcd_pkg::VALUE_WIDTH-1:0] val_a,
                                      input logic [mmcd_pkg::POS_WIDTH-1:0] pos_b,
                                      input logic [mmcd_pkg::VALUE_WIDTH-1:0] val_b,
                                      input logic [mmcd_pkg::COLUMN_WIDTH-1:0] column,
                                      input logic last);
        step_t st;
        st = '{default: '0};
        st.sample.sample_pos = pos;
        st.sample.sample_val = val;
        st.typed = 1'b1;
        st.want.first_pos = pos_a;
        st.want.first_val = val_a;
        st.want.second_pos = pos_b;
        st.want.second_val = val_b;
        st.want.column_index = column;
        st.want.frame_last = last;
        directed_steps.push_back(st);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endtask

    task automatic check_column(input mmcd_pkg::out_item_t got);
        mmcd_pkg::out_item_t want;
        if (pending_columns.size() == 0)
        begin
            failures++;
            $error("unexpected column result, column_index %0d", got.column_index);
        end
        else
        begin
            want = pending_columns.pop_front();
            compare_field("first_pos", want.first_pos, got.first_pos);
            compare_field("first_val", want.first_val, got.first_val);
            compare_field("second_pos", want.second_pos, got.second_pos);
            compare_field("second_val", want.second_val, got.second_val);
            compare_field("column_index", want.column_index, got.column_index);
            compare_field("frame_last", want.frame_last, got.frame_last);
        end
    endtask

    // Sink side: checks every accepted request and stalls at random.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                check_column(out_item);
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady_flow || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    task automatic offer_sample(input mmcd_pkg::in_item_t s, input bit typed,
                                input mmcd_pkg::out_item_t want);
        mmcd_pkg::out_item_t got;
        bit produced;
        int gap;
        in_item <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        produced = fold_sample(s, got);
        if (typed)
        begin
            pending_columns.push_back(want);
        end
        else if (produced)
        begin
            pending_columns.push_back(got);
        end
        gap = 0;
        while (!steady_flow && $urandom_range(0, 99) < 35)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_columns.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic write_register(input logic [mmcd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [mmcd_pkg::CFG_DATA_WIDTH-1:0] data);
        settle();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            mmcd_pkg::CFG_POINT_COUNT:
            begin
                points_reg = data;
                open_frame();
            end
            mmcd_pkg::CFG_PIXEL_COUNT:
            begin
                columns_reg = data[mmcd_pkg::PIXEL_WIDTH-1:0];
                open_frame();
            end
            mmcd_pkg::CFG_ENVELOPE_MODE: envelope_reg = data[0];
            default: ;
        endcase
    endtask

    initial
    begin
        logic [mmcd_pkg::CFG_DATA_WIDTH-1:0] points;
        logic [mmcd_pkg::CFG_DATA_WIDTH-1:0] columns;
        points_reg = mmcd_pkg::POINT_COUNT_RESET;
        columns_reg = mmcd_pkg::PIXEL_COUNT_RESET;
        envelope_reg = 1'b0;
        open_frame();

        add_write(mmcd_pkg::CFG_POINT_COUNT, 24'd1);
        add_typed(32'h0, 24'h800000, 32'h0, 24'h800000, 32'h0, 24'h800000, 12'd0, 1'b1);
        add_typed(32'hFFFFFFFF, 24'h7FFFFF, 32'hFFFFFFFF, 24'h7FFFFF,
                  32'hFFFFFFFF, 24'h7FFFFF, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_ENVELOPE_MODE, 24'd1);
        add_typed(32'hFFFFFFFF, 24'h0, 32'hFFFFFFFF, 24'h0, 32'hFFFFFFFF, 24'h0, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_POINT_COUNT, 24'd2);
        add_write(mmcd_pkg::CFG_PIXEL_COUNT, 24'd1);
        add_sample(32'hFFFFFFFF, 24'd5);
        add_typed(32'hFFFFFFFE, 24'hFFFFFD, 32'hFFFFFFFE, 24'hFFFFFD,
                  32'hFFFFFFFE, 24'd5, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_ENVELOPE_MODE, 24'd0);
        add_sample(32'd10, 24'd7);
        add_typed(32'd20, 24'hFFFFF9, 32'd10, 24'd7, 32'd20, 24'hFFFFF9, 12'd0, 1'b1);
        add_sample(32'd10, 24'hFFFFF9);
        add_typed(32'd20, 24'd7, 32'd10, 24'hFFFFF9, 32'd20, 24'd7, 12'd0, 1'b1);
        add_sample(32'd30, 24'd4);
        add_typed(32'd40, 24'd4, 32'd30, 24'd4, 32'd30, 24'd4, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_PIXEL_COUNT, 24'd0);
        add_sample(32'd1, 24'd1);
        add_typed(32'd2, 24'd2, 32'd1, 24'd1, 32'd2, 24'd2, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_POINT_COUNT, 24'd0);
        add_typed(32'd9, 24'hFFFFFF, 32'd9, 24'hFFFFFF, 32'd9, 24'hFFFFFF, 12'd0, 1'b1);
        add_write(mmcd_pkg::CFG_POINT_COUNT, 24'd3);
        add_write(mmcd_pkg::CFG_PIXEL_COUNT, 24'd8191);
        add_typed(32'd100, 24'd3, 32'd100, 24'd3, 32'd100, 24'd3, 12'd0, 1'b0);
        add_typed(32'd101, 24'h800000, 32'd101, 24'h800000, 32'd101, 24'h800000, 12'd1, 1'b0);
        add_typed(32'd102, 24'h7FFFFF, 32'd102, 24'h7FFFFF, 32'd102, 24'h7FFFFF, 12'd2, 1'b1);
        add_typed(32'd103, 24'd0, 32'd103, 24'd0, 32'd103, 24'd0, 12'd0, 1'b0);
        add_write(CFG_UNUSED_INDEX, 24'hFFFFFF);
        add_typed(32'd104, 24'd1, 32'd104, 24'd1, 32'd104, 24'd1, 12'd1, 1'b0);
        add_typed(32'd105, 24'd2, 32'd105, 24'd2, 32'd105, 24'd2, 12'd2, 1'b1);
        add_write(mmcd_pkg::CFG_POINT_COUNT, 24'd5);
        add_write(mmcd_pkg::CFG_PIXEL_COUNT, 24'd2);
        add_write(mmcd_pkg::CFG_ENVELOPE_MODE, 24'd1);
        add_sample(32'd200, 24'd9);
        add_sample(32'd201, 24'd9);
        add_sample(32'd202, 24'hFFFFFE);
        add_sample(32'd203, 24'd5);
        add_sample(32'd204, 24'hFFFFFE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].write)
            begin
                write_register(directed_steps[i].index, directed_steps[i].data);
            end
            else
            begin
                offer_sample(directed_steps[i].sample, directed_steps[i].typed,
                             directed_steps[i].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0: points = 24'd0;
                1: points = 24'd1;
                7, 8: points = $urandom_range(25, 200);
                9: points = $urandom_range(201, 2000);
                default: points = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 5))
                0: columns = 24'd0;
                1: columns = 24'd8191;
                2: columns = $urandom_range(0, 8191);
                default: columns = $urandom_range(1, 8);
            endcase
            write_register(mmcd_pkg::CFG_POINT_COUNT, points);
            write_register(mmcd_pkg::CFG_PIXEL_COUNT, columns);
            write_register(mmcd_pkg::CFG_ENVELOPE_MODE, 24'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
            begin
                write_register(CFG_UNUSED_INDEX, 24'($urandom));
            end
            repeat (PHASE_SAMPLES)
            begin
                offer_sample(random_sample(), 1'b0, '0);
                if ($urandom_range(0, 49) == 0)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_columns.size() != 0);
                end
            end
        end

        write_register(mmcd_pkg::CFG_POINT_COUNT, 24'd4096);
        write_register(mmcd_pkg::CFG_PIXEL_COUNT, 24'd4096);
        write_register(mmcd_pkg::CFG_ENVELOPE_MODE, 24'($urandom_range(0, 1)));
        hold_request = 1'b1;
        repeat (HOLD_SAMPLES)
        begin
            offer_sample(random_sample(), 1'b0, '0);
        end

        write_register(mmcd_pkg::CFG_POINT_COUNT, 24'd300);
        write_register(mmcd_pkg::CFG_PIXEL_COUNT, 24'd4096);
        write_register(mmcd_pkg::CFG_ENVELOPE_MODE, 24'd0);
        steady_flow = 1'b1;
        repeat (STEADY_SAMPLES)
        begin
            offer_sample(random_sample(), 1'b0, '0);
        end
        steady_flow = 1'b0;

        settle();
        if (failures == 0 && pending_columns.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
